// ===== sv/nnt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nnt_pkg: shared types and constants of the nearest-neighbour tour block
// Word formats, request codes, controller states and the control bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nnt_pkg;

	localparam int MAX_VERTICES_DEF = 32;
	localparam int DIST_WIDTH_DEF   = 32;
	// most vertices one tour may cover (results per tour less one)
	localparam int TOUR_CAP         = 32;
	localparam logic [5:0] NUM_VERTICES_RST = 6'd32;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_START = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [4:0]  row_index;
		logic [4:0]  col_index;
		logic [31:0] distance;
		logic [5:0]  start_vertex;
	} req_word_t;

	typedef struct packed {
		logic [5:0] tour_vertex;
		logic       last;
	} tour_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_READ,
		ST_DRAIN,
		ST_PUT,
		ST_CLOSE
	} state_t;

	typedef struct packed {
		logic load_we;
		logic start;
		logic emit_start;
		logic emit_pick;
		logic emit_close;
		logic scan_init;
		logic scan_read;
	} cmd_t;

	typedef struct packed {
		logic start_ok;
		logic scan_done;
		logic tour_done;
		logic single;
		logic slot_free;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/nearest_neighbour_tour.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbour_tour: greedy nearest-neighbour tour over a distance matrix
// Load words fill the distance matrix; a start word emits the tour.
// ----------------------------------------------------------------------------
// A start word for n vertices emits n+1 tour words (start vertex, each
// nearest unvisited vertex, start vertex again with last set). Every step
// scans the current row of the distance memory one entry a cycle through its
// single registered read port, then a drain state finishes the compare and a
// put state issues the word. A start vertex of zero or above the vertex count
// is dropped with no output. The vertex count register may be written only
// while no tour is running.
// ----------------------------------------------------------------------------
module nearest_neighbour_tour
	import nnt_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int DIST_WIDTH   = DIST_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire req_word_t  req,
	output logic            tour_valid,
	input  wire logic       tour_ready,
	output tour_word_t      tour,
	input  wire logic       cfg_we,
	input  wire logic [5:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	nnt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req.req_type),
		.status    (status),
		.cmd       (cmd)
	);

	nnt_dpath #(
		.MAX_VERTICES (MAX_VERTICES),
		.DIST_WIDTH   (DIST_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.status     (status),
		.tour_valid (tour_valid),
		.tour_ready (tour_ready),
		.tour       (tour)
	);

endmodule
`default_nettype wire

// ===== sv/nnt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nnt_ctrl: tour sequencer
// Accepts request words, steps through the emit and row-scan phases of a
// tour and drives the datapath by commands.
// ----------------------------------------------------------------------------
module nnt_ctrl
	import nnt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_ready,
	input  wire logic    req_type,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q, state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		accept    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				accept    = req_valid;
				if (accept && req_type == REQ_LOAD) begin
					cmd.load_we = 1'b1;
				end
				if (accept && req_type == REQ_START && status.start_ok) begin
					cmd.start = 1'b1;
					state_d   = ST_FIRST;
				end
			end
			ST_FIRST: begin
				if (status.slot_free) begin
					cmd.emit_start = 1'b1;
					cmd.scan_init  = 1'b1;
					state_d        = status.single ? ST_CLOSE : ST_READ;
				end
			end
			ST_READ: begin
				cmd.scan_read = 1'b1;
				if (status.scan_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last entry of the row is compared here
				state_d = ST_PUT;
			end
			ST_PUT: begin
				if (status.slot_free) begin
					cmd.emit_pick = 1'b1;
					cmd.scan_init = 1'b1;
					state_d       = status.tour_done ? ST_CLOSE : ST_READ;
				end
			end
			ST_CLOSE: begin
				if (status.slot_free) begin
					cmd.emit_close = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/nnt_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nnt_dpath: distance store, row scan and output register
// Holds the distance memory, the visited marks and the running minimum of
// the row scan, and registers each tour word for the output channel.
// ----------------------------------------------------------------------------
module nnt_dpath
	import nnt_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int DIST_WIDTH   = DIST_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire req_word_t  req,
	input  wire logic       cfg_we,
	input  wire logic [5:0] cfg_data,
	input  wire cmd_t       cmd,
	output status_t         status,
	output logic            tour_valid,
	input  wire logic       tour_ready,
	output tour_word_t      tour
);

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int AW    = $clog2(MAX_VERTICES * MAX_VERTICES);
	localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam logic [5:0] MAX_COUNT =
		(MAX_VERTICES < TOUR_CAP) ? 6'(MAX_VERTICES) : 6'(TOUR_CAP);

	logic [DIST_WIDTH-1:0]   mem [DEPTH];
	logic [DIST_WIDTH-1:0]   rd_data_s1;
	logic                    rd_valid_s1;
	logic [VW-1:0]           j_s1;

	logic [5:0]              num_vertices_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           step_q;
	logic [VW-1:0]           start_q;
	logic [VW-1:0]           cur_q;
	logic [VW-1:0]           j_q;
	logic [VW-1:0]           pick_q;
	logic [DIST_WIDTH-1:0]   best_q;
	logic                    found_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic                    out_valid_q;
	tour_word_t              out_q;

	logic [5:0]    n_eff;
	logic [5:0]    sv_m1;
	logic          load_in_range;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          better;

	always_comb begin
		if (num_vertices_q == 6'd0) begin
			n_eff = 6'd1;
		end else if (num_vertices_q > MAX_COUNT) begin
			n_eff = MAX_COUNT;
		end else begin
			n_eff = num_vertices_q;
		end
	end

	assign sv_m1         = req.start_vertex - 6'd1;
	assign load_in_range = (int'(req.row_index) < MAX_VERTICES)
		&& (int'(req.col_index) < MAX_VERTICES);
	assign wr_addr = AW'(req.row_index) * AW'(MAX_VERTICES) + AW'(req.col_index);
	assign rd_addr = AW'(cur_q) * AW'(MAX_VERTICES) + AW'(j_q);
	assign better  = rd_valid_s1 && !visited_q[j_s1]
		&& (!found_q || rd_data_s1 < best_q);

	assign status.start_ok  = (req.start_vertex != 6'd0) && (req.start_vertex <= n_eff);
	assign status.scan_done = (CW'(j_q) == count_q - CW'(1));
	assign status.tour_done = ((step_q + CW'(1)) == count_q);
	assign status.single    = (count_q == CW'(1));
	assign status.slot_free = !out_valid_q || tour_ready;

	// distance memory: one write port for loads, one registered read for the scan
	always_ff @(posedge clk) begin
		if (cmd.load_we && load_in_range) begin
			mem[wr_addr] <= DIST_WIDTH'(req.distance);
		end
		rd_data_s1 <= mem[rd_addr];
		j_s1       <= j_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vertices_q <= NUM_VERTICES_RST;
			rd_valid_s1    <= 1'b0;
			count_q        <= '0;
			step_q         <= '0;
			start_q        <= '0;
			cur_q          <= '0;
			j_q            <= '0;
			pick_q         <= '0;
			best_q         <= '0;
			found_q        <= 1'b0;
			visited_q      <= '0;
		end else begin
			if (cfg_we) begin
				num_vertices_q <= cfg_data;
			end
			rd_valid_s1 <= cmd.scan_read;
			if (cmd.start) begin
				count_q   <= n_eff[CW-1:0];
				start_q   <= sv_m1[VW-1:0];
				cur_q     <= sv_m1[VW-1:0];
				visited_q <= MAX_VERTICES'(1) << sv_m1[VW-1:0];
				step_q    <= CW'(1);
			end
			if (cmd.scan_init) begin
				j_q     <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_read) begin
				j_q <= j_q + VW'(1);
			end
			// strict less-than keeps the lowest index on a tie
			if (better) begin
				found_q <= 1'b1;
				best_q  <= rd_data_s1;
				pick_q  <= j_s1;
			end
			if (cmd.emit_pick) begin
				visited_q[pick_q] <= 1'b1;
				cur_q             <= pick_q;
				step_q            <= step_q + CW'(1);
			end
		end
	end

	// output register parts the scan from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_start || cmd.emit_pick || cmd.emit_close) begin
			out_valid_q <= 1'b1;
		end else if (tour_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_start || cmd.emit_close) begin
			out_q.tour_vertex <= 6'(start_q) + 6'd1;
			out_q.last        <= cmd.emit_close;
		end else if (cmd.emit_pick) begin
			out_q.tour_vertex <= 6'(pick_q) + 6'd1;
			out_q.last        <= 1'b0;
		end
	end

	assign tour_valid = out_valid_q;
	assign tour       = out_q;

`ifndef ASSERT_OFF
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_start || cmd.emit_pick || cmd.emit_close) |-> status.slot_free)
		else $error("tour word issued while output register is held");

	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_start, cmd.emit_pick, cmd.emit_close}))
		else $error("more than one tour word issued in a cycle");

	a_pick_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_pick |-> (found_q && !visited_q[pick_q]))
		else $error("picked vertex was already visited");

	a_close_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_close |-> (step_q == count_q))
		else $error("tour closed before every vertex was visited");
`endif

endmodule
`default_nettype wire
